// File: rtl/sobel_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sobel edge detector
package sobel_pkg;

  localparam int PixW    = 8;
  localparam int CfgW    = 11;
  localparam int ThrW    = 8;
  localparam int CfgIdxW = 2;
  localparam int GradW   = 11;
  localparam int SumW    = 21;
  localparam int RootW   = 8;
  localparam int RadW    = 2 * RootW;

  localparam logic [CfgW-1:0] MinSize   = 11'd3;
  localparam logic [CfgW-1:0] DefWidth  = 11'd640;
  localparam logic [CfgW-1:0] DefHeight = 11'd480;
  localparam logic [ThrW-1:0] DefThr    = 8'd73;
  localparam logic            DefThrEn  = 1'b1;
  localparam logic [PixW-1:0] PixMax    = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth      = 2'd0,
    CfgImageHeight     = 2'd1,
    CfgThresholdLevel  = 2'd2,
    CfgThresholdEnable = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            flush;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] edge_value;
    logic            last_pixel;
  } edge_out_t;

  // per-request control that rides along the pipeline
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } tag_t;

endpackage

// File: rtl/sobel_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module sobel_ram #(
  parameter int DataW = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sobel_grad.sv
`timescale 1ns / 1ps
// 3x3 window, sobel gradients and sum of squares
module sobel_grad (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  sobel_pkg::tag_t               tag_i,
  input  logic [sobel_pkg::PixW-1:0]    top_i,
  input  logic [sobel_pkg::PixW-1:0]    mid_i,
  input  logic [sobel_pkg::PixW-1:0]    pix_i,
  output logic                          valid_o,
  output sobel_pkg::tag_t               tag_o,
  output logic [sobel_pkg::SumW-1:0]    sum_o
);
  import sobel_pkg::*;

  localparam int AccW = PixW + 2;

  logic [PixW-1:0] win_q [9];
  logic            v2_q, v3_q, v4_q;
  tag_t            tag2_q, tag3_q, tag4_q;

  logic signed [GradW-1:0]   gx_d, gy_d, gx_q, gy_q;
  logic [AccW-1:0]           gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [2*GradW-1:0] sq_x, sq_y;
  logic [SumW-1:0]           sum_d, sum_q;

  // window shifts left, new column on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (en_i && valid_i) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= top_i;
      win_q[5] <= mid_i;
      win_q[8] <= pix_i;
    end
  end

  always_comb begin
    gx_pos = {2'b00, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b00, win_q[8]};
    gx_neg = {2'b00, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b00, win_q[6]};
    gy_pos = {2'b00, win_q[6]} + {1'b0, win_q[7], 1'b0} + {2'b00, win_q[8]};
    gy_neg = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, win_q[2]};
    gx_d   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy_d   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    sq_x   = gx_q * gx_q;
    sq_y   = gy_q * gy_q;
    sum_d  = SumW'(sq_x[SumW-2:0]) + SumW'(sq_y[SumW-2:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag2_q <= tag_i;
      tag3_q <= tag2_q;
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      tag4_q <= tag3_q;
      sum_q  <= sum_d;
    end
  end

  assign valid_o = v4_q;
  assign tag_o   = tag4_q;
  assign sum_o   = sum_q;

endmodule

// File: rtl/sobel_sqrt.sv
`timescale 1ns / 1ps
// pipelined digit-by-digit integer square root, one root bit per stage
module sobel_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  sobel_pkg::tag_t              tag_i,
  input  logic                         sat_i,
  input  logic [sobel_pkg::RadW-1:0]   radicand_i,
  output logic                         valid_o,
  output sobel_pkg::tag_t              tag_o,
  output logic                         sat_o,
  output logic [sobel_pkg::RootW-1:0]  root_o
);
  import sobel_pkg::*;

  localparam int Steps = RootW;
  localparam int RemW  = RootW + 4;

  logic             valid_q [Steps];
  tag_t             tag_q   [Steps];
  logic             sat_q   [Steps];
  logic [RadW-1:0]  rad_q   [Steps];
  logic [RemW-1:0]  rem_q   [Steps];
  logic [RootW-1:0] root_q  [Steps];

  logic [RadW-1:0]  prev_rad  [Steps];
  logic [RemW-1:0]  prev_rem  [Steps];
  logic [RootW-1:0] prev_root [Steps];
  logic [RemW-1:0]  cur       [Steps];
  logic [RemW-1:0]  trial     [Steps];
  logic [RemW-1:0]  rem_d     [Steps];
  logic [RootW-1:0] root_d    [Steps];

  always_comb begin
    prev_rad[0]  = radicand_i;
    prev_rem[0]  = '0;
    prev_root[0] = '0;
    for (int i = 1; i < Steps; i++) begin
      prev_rad[i]  = rad_q[i-1];
      prev_rem[i]  = rem_q[i-1];
      prev_root[i] = root_q[i-1];
    end
    for (int i = 0; i < Steps; i++) begin
      cur[i]   = {prev_rem[i][RemW-3:0], prev_rad[i][2*(Steps-1-i) +: 2]};
      trial[i] = {{(RemW-RootW-2){1'b0}}, prev_root[i], 2'b01};
      if (cur[i] >= trial[i]) begin
        rem_d[i]  = cur[i] - trial[i];
        root_d[i] = {prev_root[i][RootW-2:0], 1'b1};
      end else begin
        rem_d[i]  = cur[i];
        root_d[i] = {prev_root[i][RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Steps; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < Steps; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      sat_q[0] <= sat_i;
      for (int i = 1; i < Steps; i++) begin
        tag_q[i] <= tag_q[i-1];
        sat_q[i] <= sat_q[i-1];
      end
      for (int i = 0; i < Steps; i++) begin
        rad_q[i]  <= prev_rad[i];
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign tag_o   = tag_q[Steps-1];
  assign sat_o   = sat_q[Steps-1];
  assign root_o  = root_q[Steps-1];

endmodule

// File: rtl/sobel_edge_threshold_top.sv
`timescale 1ns / 1ps
// sobel edge detector top level: position tracking, line store, output register
// results pass the first stage, the gradient and root pipelines and the output register;
//   each result belongs to the pixel one row and one column behind the input
// throughput: one input request per cycle while the output register can take a value;
//   the line store reads a column at accept and writes it back from the first stage
// reset: position, window and registers return to defaults; line store content is not cleared
module sobel_edge_threshold_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input requests
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sobel_pkg::pix_in_t                in_data_i,
  // result requests
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sobel_pkg::edge_out_t              out_data_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [sobel_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sobel_pkg::CfgW-1:0]        cfg_wdata_i
);
  import sobel_pkg::*;

  // column index covers the line store, row index reaches two past the last row
  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT + 2);
  localparam int MaxPW = (RowW > ColW) ? RowW : ColW;
  localparam int PosW = ((MaxPW > CfgW) ? MaxPW : CfgW) + 1;
  localparam int LineW = 2 * PixW;

  localparam logic [CfgW-1:0] ResetWidth  = (MAX_WIDTH < 640) ? CfgW'(MAX_WIDTH) : DefWidth;
  localparam logic [CfgW-1:0] ResetHeight = (MAX_HEIGHT < 480) ? CfgW'(MAX_HEIGHT) : DefHeight;

  // configuration registers
  logic [CfgW-1:0] width_q, height_q;
  logic [ThrW-1:0] thr_q;
  logic            thr_en_q;
  logic [CfgW-1:0] width_clamp, height_clamp;
  logic            restart;

  // input position
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PosW-1:0] c_ext, r_ext, w_ext, h_ext, orow, ocol, c_inc;
  tag_t            tag_d;

  // handshake and pipeline control
  logic advance;
  logic accept;

  // first stage: line store read in flight
  logic            s1_valid_q;
  logic [ColW-1:0] s1_col_q;
  logic [PixW-1:0] s1_pix_q;
  tag_t            s1_tag_q;
  logic [PixW-1:0] pix_in;

  // line store, upper row in the high byte, middle row in the low byte
  logic             ram_we;
  logic [LineW-1:0] ram_wdata, ram_rdata, line_data;
  logic             fwd_q;
  logic [LineW-1:0] fwd_data_q;

  // gradient and root pipeline
  logic             grad_valid;
  tag_t             grad_tag;
  logic [SumW-1:0]  grad_sum;
  logic             root_valid;
  tag_t             root_tag;
  logic             root_sat;
  logic [RootW-1:0] root;
  logic [PixW-1:0]  mag, edge_d;

  // output register
  logic      out_valid_q;
  edge_out_t out_data_q;

  // ---------------------------------------------------------------------------
  // configuration: sizes are clamped on write, a size write restarts the image
  // ---------------------------------------------------------------------------
  always_comb begin
    if (cfg_wdata_i < MinSize) begin
      width_clamp = MinSize;
    end else if (int'(cfg_wdata_i) > MAX_WIDTH) begin
      width_clamp = CfgW'(MAX_WIDTH);
    end else begin
      width_clamp = cfg_wdata_i;
    end
    if (cfg_wdata_i < MinSize) begin
      height_clamp = MinSize;
    end else if (int'(cfg_wdata_i) > MAX_HEIGHT) begin
      height_clamp = CfgW'(MAX_HEIGHT);
    end else begin
      height_clamp = cfg_wdata_i;
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_i == CfgImageWidth) || (cfg_idx_i == CfgImageHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      thr_q    <= DefThr;
      thr_en_q <= DefThrEn;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:      width_q  <= width_clamp;
        CfgImageHeight:     height_q <= height_clamp;
        CfgThresholdLevel:  thr_q    <= cfg_wdata_i[ThrW-1:0];
        CfgThresholdEnable: thr_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the whole pipeline moves whenever the output register can take a value
  // ---------------------------------------------------------------------------
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  // ---------------------------------------------------------------------------
  // position of the incoming request and of the result it releases
  // ---------------------------------------------------------------------------
  always_comb begin
    c_ext = PosW'(col_q);
    r_ext = PosW'(row_q);
    w_ext = PosW'(width_q);
    h_ext = PosW'(height_q);
    // a result leaves one row and one column behind the input
    tag_d.emit = (r_ext >= PosW'(2)) || ((r_ext == PosW'(1)) && (c_ext != '0));
    if (c_ext != '0) begin
      orow = r_ext - PosW'(1);
      ocol = c_ext - PosW'(1);
    end else begin
      // first column: the result is the last pixel of the row two above
      orow = r_ext - PosW'(2);
      ocol = w_ext - PosW'(1);
    end
    tag_d.interior = (orow != '0) && (orow < h_ext - PosW'(1))
                  && (ocol != '0) && (ocol < w_ext - PosW'(1));
    tag_d.last = tag_d.emit && (orow == h_ext - PosW'(1)) && (ocol == w_ext - PosW'(1));
    c_inc = c_ext + PosW'(1);
    if (tag_d.last) begin
      col_d = '0;
      row_d = '0;
    end else if (c_inc >= w_ext) begin
      col_d = '0;
      row_d = row_q + RowW'(1);
    end else begin
      col_d = ColW'(c_inc);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // flush requests enter as zero pixels
  assign pix_in = in_data_i.flush ? '0 : in_data_i.pixel_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q <= col_q;
      s1_pix_q <= pix_in;
      s1_tag_q <= tag_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line store: read the column at accept, write it back from the first stage as the pipeline advances later
  // ---------------------------------------------------------------------------
  assign ram_we    = advance && s1_valid_q;
  assign line_data = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_wdata = {line_data[PixW-1:0], s1_pix_q};

  sobel_ram #(
    .DataW (LineW),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // same column read and written in the same cycle (image restart): forward the new line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= ram_we && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // window, gradients and magnitude
  // ---------------------------------------------------------------------------
  sobel_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (s1_valid_q),
    .tag_i   (s1_tag_q),
    .top_i   (line_data[LineW-1:PixW]),
    .mid_i   (line_data[PixW-1:0]),
    .pix_i   (s1_pix_q),
    .valid_o (grad_valid),
    .tag_o   (grad_tag),
    .sum_o   (grad_sum)
  );

  // sums of 65536 and above saturate to 255
  sobel_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .valid_i    (grad_valid),
    .tag_i      (grad_tag),
    .sat_i      (grad_sum[SumW-1:RadW] != '0),
    .radicand_i (grad_sum[RadW-1:0]),
    .valid_o    (root_valid),
    .tag_o      (root_tag),
    .sat_o      (root_sat),
    .root_o     (root)
  );

  // ---------------------------------------------------------------------------
  // threshold and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    mag = root_sat ? PixMax : root;
    if (!root_tag.interior) begin
      edge_d = '0;
    end else if (thr_en_q) begin
      edge_d = (mag > thr_q) ? PixMax : '0;
    end else begin
      edge_d = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= root_valid && root_tag.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.edge_value <= edge_d;
      out_data_q.last_pixel <= root_tag.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // column never reaches the row width
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PosW'(col_q) < PosW'(width_q))
    else $error("column index out of row");

  // row never passes the flush rows
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PosW'(row_q) <= PosW'(height_q) + PosW'(1))
    else $error("row index past flush rows");

  // the last pixel of an image is a border pixel
  a_last_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_pixel) |-> (out_data_o.edge_value == '0))
    else $error("last pixel carries a nonzero edge");

  // a line store write at the column being read sets the forward flag
  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ram_we && (s1_col_q == col_q)) |=> fwd_q)
    else $error("line store collision not forwarded");
`endif

endmodule

// File: bench/sobel_edge_threshold_checker.sv
`timescale 1ns / 1ps
// sobel edge detector result predictor and scoreboard
module sobel_edge_threshold_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  sobel_pkg::pix_in_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  sobel_pkg::edge_out_t          out_data_i,
  input  logic                          cfg_we_i,
  input  logic [sobel_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sobel_pkg::CfgW-1:0]    cfg_wdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   request_count_o,
  output int unsigned                   result_count_o,
  output int unsigned                   image_count_o
);

  logic [7:0] upper_line  [MAX_WIDTH];
  logic [7:0] middle_line [MAX_WIDTH];
  logic [7:0] win [9];
  int unsigned col, row;
  int unsigned img_w, img_h;
  logic [sobel_pkg::ThrW-1:0] thr_level;
  logic thr_en;
  sobel_pkg::edge_out_t edge_expect_q [$];
  int unsigned fail_count, request_count, result_count, image_count;

  assign fail_count_o    = fail_count;
  assign request_count_o = request_count;
  assign result_count_o  = result_count;
  assign image_count_o   = image_count;

  function automatic int unsigned clamp_dim(input logic [sobel_pkg::CfgW-1:0] raw,
                                            input int unsigned hi);
    if (raw < sobel_pkg::MinSize) return sobel_pkg::MinSize;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // integer square root, saturated at 255
  function automatic logic [7:0] grad_magnitude(input int gx, input int gy);
    int unsigned sq, root, trial, probe;
    sq = gx * gx + gy * gy;
    if (sq >= 32'd65536) return sobel_pkg::PixMax;
    root = 0;
    for (probe = 128; probe != 0; probe = probe >> 1) begin
      trial = root | probe;
      if (trial * trial <= sq) root = trial;
    end
    return root[7:0];
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    fail_count++;
    $display("%0t %s expected %0d got %0d", $time, field, want, got);
  endtask

  task automatic check_result(input sobel_pkg::edge_out_t got);
    sobel_pkg::edge_out_t want;
    result_count++;
    if (got.last_pixel === 1'b1) image_count++;
    if (edge_expect_q.size() == 0) begin
      report_mismatch("unrequested result, edge_value (none pending)", -1, got.edge_value);
      return;
    end
    want = edge_expect_q.pop_front();
    if (got.edge_value !== want.edge_value)
      report_mismatch("edge_value", want.edge_value, got.edge_value);
    if (got.last_pixel !== want.last_pixel)
      report_mismatch("last_pixel", want.last_pixel, got.last_pixel);
  endtask

  task automatic apply_write(input logic [sobel_pkg::CfgIdxW-1:0] idx,
                             input logic [sobel_pkg::CfgW-1:0] val);
    case (sobel_pkg::cfg_idx_e'(idx))
      sobel_pkg::CfgImageWidth: begin
        img_w = clamp_dim(val, MAX_WIDTH);
        col = 0;
        row = 0;
      end
      sobel_pkg::CfgImageHeight: begin
        img_h = clamp_dim(val, MAX_HEIGHT);
        col = 0;
        row = 0;
      end
      sobel_pkg::CfgThresholdLevel:  thr_level = val[sobel_pkg::ThrW-1:0];
      sobel_pkg::CfgThresholdEnable: thr_en = val[0];
      default: ;
    endcase
  endtask

  // shift the request into line stores and window, queue the result it releases
  task automatic predict_edge(input sobel_pkg::pix_in_t req);
    logic [7:0] pix, top, mid;
    logic has_result, is_last;
    int unsigned orow, ocol;
    int gx, gy;
    logic [7:0] mag;
    sobel_pkg::edge_out_t res;
    request_count++;
    pix = req.flush ? 8'h00 : req.pixel_value;
    top = upper_line[col];
    mid = middle_line[col];
    upper_line[col]  = mid;
    middle_line[col] = pix;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    has_result = (row >= 2) || (row == 1 && col >= 1);
    is_last = 1'b0;
    if (has_result) begin
      if (col >= 1) begin
        orow = row - 1;
        ocol = col - 1;
      end else begin
        orow = row - 2;
        ocol = img_w - 1;
      end
      res.edge_value = 8'h00;
      if (orow != 0 && orow < img_h - 1 && ocol != 0 && ocol < img_w - 1) begin
        gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
        gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        mag = grad_magnitude(gx, gy);
        if (thr_en) res.edge_value = (mag > thr_level) ? sobel_pkg::PixMax : 8'h00;
        else res.edge_value = mag;
      end
      is_last = (orow == img_h - 1) && (ocol == img_w - 1);
      res.last_pixel = is_last;
      edge_expect_q.push_back(res);
    end
    col++;
    if (col >= img_w) begin
      col = 0;
      row++;
    end
    if (is_last) begin
      col = 0;
      row = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = 8'h00;
        middle_line[i] = 8'h00;
      end
      for (int i = 0; i < 9; i++) win[i] = 8'h00;
      col = 0;
      row = 0;
      img_w = clamp_dim(sobel_pkg::DefWidth, MAX_WIDTH);
      img_h = clamp_dim(sobel_pkg::DefHeight, MAX_HEIGHT);
      thr_level = sobel_pkg::DefThr;
      thr_en = sobel_pkg::DefThrEn;
      edge_expect_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_i) predict_edge(in_data_i);
      pending_o <= edge_expect_q.size();
    end
  end

  initial begin
    fail_count    = 0;
    request_count = 0;
    result_count  = 0;
    image_count   = 0;
  end

endmodule

// File: bench/sobel_edge_threshold_top_tb.sv
`timescale 1ns / 1ps
// sobel edge detector testbench top: stimulus, idling and verdict
module sobel_edge_threshold_top_tb;
  import sobel_pkg::*;

  localparam int MaxWidth    = 1024;
  localparam int MaxHeight   = 1024;
  localparam int DrainCycles = 20;   // comfortably past the pipeline length
  localparam int RandomItems = 490;

  // pixel content styles for random images
  typedef enum int {
    PatNoise,
    PatBinary,
    PatSmooth,
    PatFaint
  } pattern_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pix_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  edge_out_t out_data;
  logic      cfg_we = 1'b0;
  cfg_idx_e  cfg_idx = CfgImageWidth;
  logic [CfgW-1:0] cfg_wdata = '0;

  int unsigned fail_count, pending, request_count, result_count, image_count;

  // idling knobs, changed per image by the stimulus
  bit          idle_on = 1'b1;
  int unsigned gap_pct = 20;
  int unsigned stall_pct = 20;
  int unsigned stall_left = 0;

  // image geometry as the block sees it after clamping
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;
  int unsigned streamed_items = 0;
  int unsigned cut_images = 0;

  sobel_edge_threshold_top #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  sobel_edge_threshold_checker #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .request_count_o(request_count),
    .result_count_o (result_count),
    .image_count_o  (image_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: with idling on, ready drops at random and stays low while stall_left counts down
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(5, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // size register value the block will actually use
  function automatic int unsigned dim_of(input logic [CfgW-1:0] raw, input int unsigned hi);
    if (raw < MinSize) return MinSize;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // mostly legal sizes, sometimes below the minimum to hit the clamp
  function automatic logic [CfgW-1:0] pick_dim(input int unsigned hi);
    if ($urandom_range(7) == 0) return CfgW'($urandom_range(2));
    return CfgW'($urandom_range(hi, 3));
  endfunction

  // threshold with junk in the unused upper bits
  function automatic logic [CfgW-1:0] pick_thr();
    logic [7:0] level;
    case ($urandom_range(4))
      0:       level = 8'h00;
      1:       level = 8'hFF;
      default: level = 8'($urandom_range(255));
    endcase
    return {3'($urandom_range(7)), level};
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel(input pattern_e pattern, input int unsigned base);
    int v;
    case (pattern)
      PatNoise:  return 8'($urandom_range(255));
      PatBinary: return $urandom_range(1) ? 8'hFF : 8'h00;
      PatSmooth: begin
        // gentle ramps land magnitudes near typical thresholds
        v = int'(base) + int'($urandom_range(24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
      end
      default:   return 8'($urandom_range(40));
    endcase
  endfunction

  // register write: one cycle of write enable, then it drops before the task returns
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CfgImageWidth) cur_w = dim_of(val, MaxWidth);
    else if (idx == CfgImageHeight) cur_h = dim_of(val, MaxHeight);
  endtask

  // one request; valid stays up across back-to-back requests
  task automatic send_item(input logic [7:0] pix, input logic fl);
    pix_in_t req;
    int unsigned gap;
    req.pixel_value = pix;
    req.flush = fl;
    if (idle_on && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    streamed_items++;
  endtask

  // drop valid and wait until every queued result is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // a whole image plus its flush tail, or only its first cut requests
  task automatic stream_image(input pattern_e pattern, input int unsigned cut);
    int unsigned total, npix, base, n;
    logic fl;
    npix  = cur_h * cur_w;
    total = npix + cur_w + 1;
    n     = (cut != 0 && cut < total) ? cut : total;
    base  = $urandom_range(255);
    for (int unsigned i = 0; i < n; i++) begin
      // odd flush inside the picture, odd real pixel in the flush tail
      if (i < npix) fl = ($urandom_range(99) < 3);
      else fl = ($urandom_range(99) >= 20);
      send_item(pick_pixel(pattern, base), fl);
    end
  endtask

  task automatic random_settings(input bit with_size);
    settle();
    if (with_size || $urandom_range(1)) begin
      write_reg(CfgImageWidth, pick_dim(12));
      write_reg(CfgImageHeight, pick_dim(8));
    end
    if ($urandom_range(1)) write_reg(CfgThresholdLevel, pick_thr());
    if ($urandom_range(1)) write_reg(CfgThresholdEnable, CfgW'($urandom_range(2047)));
  endtask

  initial begin
    int unsigned rand_start;
    bit need_size;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 step from black to white, threshold left at its reset values:
    // the center saturates; the flush tail carries two stray real pixels
    write_reg(CfgImageWidth, 11'd3);
    write_reg(CfgImageHeight, 11'd3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_item((c == 0) ? 8'h00 : ((c == 2) ? 8'hFF : 8'h80), 1'b0);
      end
    end
    for (int k = 0; k < 4; k++) send_item(8'hFF, k[0]);

    // raw magnitude; a flush carrying 0xff sits in the top-left corner and must read as 0
    settle();
    write_reg(CfgThresholdEnable, '0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'd73, 1'b0);
    for (int k = 0; k < 6; k++) send_item(8'h00, 1'b0);
    for (int k = 0; k < 4; k++) send_item(8'($urandom_range(255)), 1'b1);

    // random small images with varying registers, some cut short by a size write
    rand_start = streamed_items;
    need_size = 1'b1;
    while (streamed_items - rand_start < RandomItems) begin
      if (need_size || $urandom_range(2) == 0) random_settings(need_size);
      need_size = 1'b0;
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      if ($urandom_range(9) == 0) begin
        stream_image(pattern_e'($urandom_range(3)), $urandom_range(cur_w * cur_h + cur_w, 1));
        settle();
        cut_images++;
        need_size = 1'b1;
      end else begin
        stream_image(pattern_e'($urandom_range(3)), 0);
      end
    end

    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    for (int k = 0; k < 3; k++) begin
      random_settings(1'b1);
      stream_image(pattern_e'($urandom_range(3)), 0);
    end

    settle();
    $display("covered %0d pixel requests: %0d full images, %0d cut short, %0d results compared",
             request_count, image_count, cut_images, result_count);
    $display("sizes 3 to 12 wide and 3 to 8 tall, undersized writes clamped, raw and thresholded output");
    if (fail_count == 0 && pending == 0) begin
      $display("sobel_edge_threshold_top: match");
    end else begin
      $display("sobel_edge_threshold_top: mismatch");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("sobel_edge_threshold_top: mismatch");
    $finish;
  end

endmodule
